// File: hdl/lzpt_pkg.sv
package lzpt_pkg;

  typedef struct packed {
    logic [3:0] symbol;
    logic       new_sequence;
  } in_item_t;

  typedef struct packed {
    logic [15:0] prediction;
    logic        codeword_end;
    logic [31:0] item_index;
    logic [31:0] codeword_count;
    logic        pool_full;
  } out_item_t;

  localparam logic [0:0] REG_ALPHABET_SIZE = 1'b0;
  localparam logic [0:0] REG_MAX_COUNT     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SUM,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } back_state_t;

endpackage

// File: hdl/lz_parse_tree_predictor_unit.sv
// Each accepted request passes a node row sweep, a bit-serial divider and the count update
// and child set-up; a request with new_sequence first re-initialises the root row.
// One request is processed at a time; a two-entry queue takes requests meanwhile.
// Reset (rst, synchronous) clears the tree and runs a root initialisation;
// requests are queued during it, and in_stall is high while rst is.
module lz_parse_tree_predictor_unit #(
  parameter int MAX_NODES    = 1024,
  parameter int MAX_ALPHABET = 16,
  parameter int COUNT_BITS   = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lzpt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lzpt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  logic [4:0] alphabet_size;
  logic [7:0] max_count;
  logic q_valid, q_pop;
  lzpt_pkg::in_item_t q_data;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= 5'd2;
      max_count <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        lzpt_pkg::REG_ALPHABET_SIZE: alphabet_size <= cfg_data[4:0];
        lzpt_pkg::REG_MAX_COUNT:     max_count <= cfg_data;
        default: ;
      endcase
    end
  end

  lzpt_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .q_valid, .q_pop, .q_data);

  lzpt_back #(.MAX_NODES(MAX_NODES), .MAX_ALPHABET(MAX_ALPHABET),
    .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst, .alphabet_size, .max_count, .q_valid, .q_data, .q_pop,
    .out_valid, .out_stall, .out_data);

endmodule

// File: hdl/lzpt_ram.sv
module lzpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/lzpt_front.sv
module lzpt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lzpt_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output lzpt_pkg::in_item_t q_data
);

  // two-entry request queue
  lzpt_pkg::in_item_t buf0, buf1;
  logic [1:0] fill;
  logic push;

  assign in_stall = rst || (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_data   = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
    if (q_pop) begin
      buf0 <= (fill == 2'd2) ? buf1 : in_data;
      if (push) buf1 <= in_data;
    end else if (push) begin
      if (fill == 2'd0) buf0 <= in_data;
      else buf1 <= in_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> fill != 2'd0) else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3) else $error("queue fill out of range");

endmodule

// File: hdl/lzpt_back.sv
module lzpt_back #(
  parameter int MAX_NODES    = 1024,
  parameter int MAX_ALPHABET = 16,
  parameter int COUNT_BITS   = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [4:0]         alphabet_size,
  input  logic [7:0]         max_count,
  input  logic               q_valid,
  input  lzpt_pkg::in_item_t q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output lzpt_pkg::out_item_t out_data
);

  localparam int NB = $clog2(MAX_NODES);
  localparam int AB = $clog2(MAX_ALPHABET);
  localparam int CB = NB + AB;
  localparam int CELLS = MAX_NODES * MAX_ALPHABET;
  localparam int SB = COUNT_BITS + AB + 1;
  localparam int NUMB = SB + 2 * AB + 8;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  lzpt_pkg::back_state_t state, state_next;

  logic [NB:0]   nodes_used;
  logic [NB-1:0] cur;
  logic [31:0]   seq_pos, words;
  logic [AB:0]   k;
  logic [AB-1:0] sym;
  logic [AB:0]   i;
  logic          clearing;
  logic          booting;
  logic [SB-1:0] n_sum;
  logic [SB+AB-1:0] w_sum;
  logic [NUMB-1:0]  rem_q;
  logic [5:0]       dstep;
  logic [NUMB:0]    part;
  logic [NUMB-1:0]  numer;
  logic [15:0]      pred;

  // memories; a link entry holds {present, child node}
  logic cnt_we, lnk_we;
  logic [CB-1:0] cnt_waddr, cnt_raddr, lnk_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic [NB:0] lnk_wdata, lnk_rdata;

  logic [CB-1:0] slot;
  assign slot = {cur, sym};

  lzpt_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_cnt (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata));
  lzpt_ram #(.WIDTH(NB+1), .DEPTH(CELLS)) u_lnk (
    .clk, .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
    .raddr(slot), .rdata(lnk_rdata));

  always_comb begin
    if (alphabet_size < 5'd2) k = (AB+1)'(2);
    else if (32'(alphabet_size) > 32'(MAX_ALPHABET)) k = (AB+1)'(MAX_ALPHABET);
    else k = (AB+1)'(alphabet_size);
  end

  // sum phase: i counts addresses; read data comes back in the cycle after its address
  logic [COUNT_BITS:0] bumped;
  logic [COUNT_BITS-1:0] newcnt;
  logic [8+AB:0] lim_prod;
  logic [SB+8:0] limit;
  logic ends;
  assign bumped   = {1'b0, cnt_rdata} + (COUNT_BITS+1)'(k - 1'b1);
  assign newcnt   = bumped[COUNT_BITS] ? CMAX : bumped[COUNT_BITS-1:0];
  assign lim_prod = (9+AB)'(max_count) * (9+AB)'(k - 1'b1);
  assign limit    = (SB+9)'(1) + (SB+9)'(lim_prod);
  assign ends     = (SB+9)'(newcnt) <= limit;

  always_comb begin
    state_next = state;
    case (state)
      lzpt_pkg::ST_IDLE: if (q_valid) state_next = q_data.new_sequence ?
                           lzpt_pkg::ST_INIT : lzpt_pkg::ST_SUM;
      lzpt_pkg::ST_INIT: if (i == (AB+1)'(MAX_ALPHABET - 1))
                           state_next = booting ? lzpt_pkg::ST_IDLE : lzpt_pkg::ST_SUM;
      lzpt_pkg::ST_SUM:  if (i == k) state_next = lzpt_pkg::ST_DIV;
      lzpt_pkg::ST_DIV:  if (dstep == 6'(NUMB)) state_next = lzpt_pkg::ST_UPD;
      lzpt_pkg::ST_UPD:  if (i == (AB+1)'(MAX_ALPHABET + 1)) state_next = lzpt_pkg::ST_OUT;
      lzpt_pkg::ST_OUT:  if (!out_valid) state_next = lzpt_pkg::ST_IDLE;
      default:           state_next = lzpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_we = 1'b0;
    cnt_waddr = slot;
    cnt_wdata = newcnt;
    cnt_raddr = {cur, i[AB-1:0]};
    lnk_we = 1'b0;
    lnk_waddr = slot;
    lnk_wdata = {1'b1, nodes_used[NB-1:0]};
    q_pop = 1'b0;
    case (state)
      lzpt_pkg::ST_IDLE: q_pop = q_valid;
      lzpt_pkg::ST_INIT: begin
        cnt_we = 1'b1;
        cnt_waddr = {{NB{1'b0}}, i[AB-1:0]};
        cnt_wdata = COUNT_BITS'(1);
        lnk_we = 1'b1;
        lnk_waddr = {{NB{1'b0}}, i[AB-1:0]};
        lnk_wdata = '0;
      end
      lzpt_pkg::ST_DIV: cnt_raddr = slot;
      lzpt_pkg::ST_UPD: begin
        cnt_raddr = slot;
        if (i == (AB+1)'(1)) begin
          cnt_we = 1'b1;
          if (ends && !lnk_rdata[NB] && nodes_used < (NB+1)'(MAX_NODES)) lnk_we = 1'b1;
        end
        if (i > (AB+1)'(1)) begin
          cnt_we = !clearing;
          cnt_waddr = {nodes_used[NB-1:0], AB'(i - (AB+1)'(2))};
          cnt_wdata = COUNT_BITS'(1);
          lnk_we = !clearing;
          lnk_waddr = {nodes_used[NB-1:0], AB'(i - (AB+1)'(2))};
          lnk_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  assign numer = NUMB'(w_sum) * NUMB'(k - 1'b1) << 8;
  assign part  = {rem_q, numer[NUMB-1 - dstep]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzpt_pkg::ST_INIT;
      nodes_used <= (NB+1)'(1);
      cur <= '0;
      seq_pos <= '0;
      words <= '0;
      i <= '0;
      booting <= 1'b1;
      out_valid <= 1'b0;
      sym <= '0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        lzpt_pkg::ST_IDLE: begin
          i <= '0;
          n_sum <= '0;
          w_sum <= '0;
          if (q_valid) begin
            sym <= (AB+1)'(q_data.symbol) >= k ? AB'(k - 1'b1) : AB'(q_data.symbol);
            if (q_data.new_sequence) begin
              nodes_used <= (NB+1)'(1);
              cur <= '0;
              seq_pos <= '0;
              words <= '0;
            end
          end
        end
        lzpt_pkg::ST_INIT: begin
          if (i == (AB+1)'(MAX_ALPHABET - 1)) begin
            i <= '0;
            booting <= 1'b0;
          end else begin
            i <= i + 1'b1;
          end
        end
        lzpt_pkg::ST_SUM: begin
          if (i != '0) begin
            n_sum <= n_sum + SB'(cnt_rdata);
            w_sum <= w_sum + (SB+AB)'(cnt_rdata) * (SB+AB)'(i - 1'b1);
          end
          i <= i + 1'b1;
          rem_q <= '0;
          dstep <= '0;
        end
        lzpt_pkg::ST_DIV: begin
          if (dstep != 6'(NUMB)) begin
            if (part >= (NUMB+1)'(n_sum)) begin
              rem_q <= NUMB'(part - (NUMB+1)'(n_sum));
              pred <= {pred[14:0], 1'b1};
            end else begin
              rem_q <= NUMB'(part);
              pred <= {pred[14:0], 1'b0};
            end
            dstep <= dstep + 1'b1;
          end
          i <= '0;
          clearing <= 1'b0;
        end
        lzpt_pkg::ST_UPD: begin
          i <= i + 1'b1;
          if (i == (AB+1)'(1)) begin
            out_data.prediction <= pred;
            out_data.item_index <= seq_pos;
            out_data.codeword_end <= ends;
            out_data.pool_full <= 1'b0;
            seq_pos <= seq_pos + 1'b1;
            if (ends) begin
              words <= words + 1'b1;
              out_data.codeword_count <= words + 1'b1;
              cur <= '0;
              if (lnk_rdata[NB]) begin
                clearing <= 1'b1;
              end else if (nodes_used >= (NB+1)'(MAX_NODES)) begin
                out_data.pool_full <= 1'b1;
                clearing <= 1'b1;
              end
            end else begin
              out_data.codeword_count <= words;
              clearing <= 1'b1;
              cur <= (lnk_rdata[NB] && {1'b0, lnk_rdata[NB-1:0]} < nodes_used) ?
                     lnk_rdata[NB-1:0] : '0;
            end
          end
          if (i == (AB+1)'(MAX_ALPHABET + 1)) begin
            if (!clearing) nodes_used <= nodes_used + 1'b1;
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    nodes_used <= (NB+1)'(MAX_NODES)) else $error("pool overrun");
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == lzpt_pkg::ST_IDLE) else $error("pop outside idle");

endmodule

// File: dv/lz_parse_tree_predictor_unit_tb.sv
`timescale 1ns / 1ps

module lz_parse_tree_predictor_unit_tb;

  localparam int NODES = 1024;
  localparam int ALPHA = 16;
  localparam int CELLS = NODES * ALPHA;
  localparam logic [23:0] COUNT_SAT = 24'hFFFFFF;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  lzpt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lzpt_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = lzpt_pkg::REG_ALPHABET_SIZE;
  logic [7:0] cfg_data = '0;

  lz_parse_tree_predictor_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the tree and the registers
  logic [23:0] visits [0:CELLS-1];
  logic [9:0]  links  [0:CELLS-1];
  bit          linked [0:CELLS-1];
  logic [10:0] used_nodes;
  logic [9:0]  walk_node;
  logic [31:0] position;
  logic [31:0] words;
  logic [4:0]  alpha_reg;
  logic [7:0]  limit_reg;

  lzpt_pkg::out_item_t expected_q[$];
  lzpt_pkg::out_item_t typed_result;
  bit        use_typed = 1'b0;
  bit        gaps_on = 1'b1;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  int        errors = 0;
  int        quiet_cycles = 0;

  task automatic fresh_node(input int node);
    for (int i = 0; i < ALPHA; i++) begin
      visits[node*ALPHA+i] = 24'd1;
      linked[node*ALPHA+i] = 1'b0;
      links[node*ALPHA+i]  = '0;
    end
  endtask

  task automatic clear_tree();
    used_nodes = 11'd1;
    walk_node  = '0;
    position   = '0;
    words      = '0;
    fresh_node(0);
  endtask

  task automatic parse_symbol(input lzpt_pkg::in_item_t req,
                              output lzpt_pkg::out_item_t res);
    int k, sym, node, slot;
    logic [63:0] weighted, total, bumped, bound;
    k = alpha_reg;
    if (k < 2) k = 2;
    if (k > ALPHA) k = ALPHA;
    if (req.new_sequence) clear_tree();
    sym = req.symbol;
    if (sym >= k) sym = k - 1;
    node = walk_node;
    if (node >= used_nodes) node = 0;
    weighted = 0;
    total = 0;
    for (int i = 0; i < k; i++) begin
      total += visits[node*ALPHA+i];
      weighted += 64'(i) * visits[node*ALPHA+i];
    end
    res = '0;
    res.prediction = (total == 0) ? 16'd0 : 16'((weighted * (k - 1) * 256) / total);
    res.item_index = position;
    slot = node * ALPHA + sym;
    bumped = visits[slot] + 64'(k - 1);
    if (bumped > COUNT_SAT) bumped = COUNT_SAT;
    visits[slot] = bumped[23:0];
    bound = 1 + 64'(limit_reg) * (k - 1);
    if (bumped <= bound) begin
      res.codeword_end = 1'b1;
      words += 1;
      walk_node = '0;
      if (!linked[slot]) begin
        if (used_nodes < NODES) begin
          fresh_node(used_nodes);
          links[slot]  = used_nodes[9:0];
          linked[slot] = 1'b1;
          used_nodes += 1;
        end else begin
          res.pool_full = 1'b1;
        end
      end
    end else if (linked[slot] && links[slot] < used_nodes) begin
      walk_node = links[slot];
    end else begin
      walk_node = '0;
    end
    position += 1;
    res.codeword_count = words;
  endtask

  initial begin
    alpha_reg = 5'd2;
    limit_reg = 8'd1;
    for (int c = 0; c < CELLS; c++) begin
      visits[c] = '0;
      links[c]  = '0;
      linked[c] = 1'b0;
    end
    clear_tree();
  end

  // accept requests, config writes and results; compare in order
  always @(posedge clk) begin
    lzpt_pkg::out_item_t want, got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lzpt_pkg::REG_ALPHABET_SIZE) alpha_reg = cfg_data[4:0];
        else limit_reg = cfg_data;
      end
      if (in_valid && !in_stall) begin
        parse_symbol(in_data, want);
        expected_q.push_back(use_typed ? typed_result : want);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.prediction !== want.prediction) begin
            $display("%0t: prediction expected %0d got %0d", $time,
                     want.prediction, got.prediction);
            errors++;
          end
          if (got.codeword_end !== want.codeword_end) begin
            $display("%0t: codeword_end expected %0d got %0d", $time,
                     want.codeword_end, got.codeword_end);
            errors++;
          end
          if (got.item_index !== want.item_index) begin
            $display("%0t: item_index expected %0d got %0d", $time,
                     want.item_index, got.item_index);
            errors++;
          end
          if (got.codeword_count !== want.codeword_count) begin
            $display("%0t: codeword_count expected %0d got %0d", $time,
                     want.codeword_count, got.codeword_count);
            errors++;
          end
          if (got.pool_full !== want.pool_full) begin
            $display("%0t: pool_full expected %0d got %0d", $time,
                     want.pool_full, got.pool_full);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < 6);
    end
  end

  task automatic send_req(input logic [3:0] sym, input logic fresh);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{symbol: sym, new_sequence: fresh};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  typedef struct {
    logic [3:0] sym;
    logic       fresh;
    bit         typed;
    lzpt_pkg::out_item_t res;
  } stim_row_t;

  // defaults: k = 2, max_count = 1
  stim_row_t opening [] = '{
    '{4'd0,  1'b1, 1'b1, '{16'd128, 1'b1, 32'd0, 32'd1, 1'b0}},
    '{4'd15, 1'b0, 1'b1, '{16'd85,  1'b1, 32'd1, 32'd2, 1'b0}},
    '{4'd1,  1'b0, 1'b1, '{16'd128, 1'b0, 32'd2, 32'd2, 1'b0}},
    '{4'd0,  1'b0, 1'b0, '0},
    '{4'd1,  1'b0, 1'b0, '0},
    '{4'd1,  1'b0, 1'b0, '0},
    '{4'd7,  1'b0, 1'b0, '0},
    '{4'd0,  1'b0, 1'b0, '0},
    '{4'd0,  1'b0, 1'b0, '0},
    '{4'd10, 1'b1, 1'b1, '{16'd128, 1'b1, 32'd0, 32'd1, 1'b0}},
    '{4'd5,  1'b0, 1'b0, '0},
    '{4'd0,  1'b0, 1'b0, '0}
  };

  logic [7:0] alpha_picks [] = '{8'd0, 8'd1, 8'd3, 8'd5, 8'd31, 8'd255, 8'd16, 8'd9};
  logic [7:0] limit_picks [] = '{8'd255, 8'd2, 8'd1, 8'd4, 8'd0, 8'd128, 8'd3, 8'd1};

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening[r]) begin
      // step past the accepting edge before the next row's expectation is set
      #1;
      use_typed = opening[r].typed;
      typed_result = opening[r].res;
      send_req(opening[r].sym, opening[r].fresh);
    end
    #1;
    use_typed = 1'b0;
    drain();

    // long run at the widest alphabet, with a hold-off and a stretch without gaps
    write_reg(lzpt_pkg::REG_ALPHABET_SIZE, 8'd16);
    write_reg(lzpt_pkg::REG_MAX_COUNT, 8'd1);
    for (int n = 0; n < 200; n++) begin
      if (n == 50) hold_req = 1'b1;
      gaps_on = !(n >= 100 && n < 160);
      send_req(4'($urandom_range(15)), n == 0);
    end
    gaps_on = 1'b1;
    drain();

    foreach (alpha_picks[p]) begin
      write_reg(lzpt_pkg::REG_ALPHABET_SIZE, alpha_picks[p]);
      write_reg(lzpt_pkg::REG_MAX_COUNT,
                limit_picks[p] == 0 ? 8'($urandom_range(255)) : limit_picks[p]);
      for (int n = 0; n < 130; n++)
        send_req(4'($urandom_range(15)), n == 0 || $urandom_range(99) < 3);
      drain();
    end

    if (expected_q.size() == 0 && errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lzpt_pkg.sv
hdl/lzpt_ram.sv
hdl/lzpt_front.sv
hdl/lzpt_back.sv
hdl/lz_parse_tree_predictor_unit.sv
dv/lz_parse_tree_predictor_unit_tb.sv
